### rtl/rvwh_pkg.sv
package rvwh_pkg;

  localparam int MAX_MAP_SIDE  = 64;
  localparam int MAP_SIDE_LOG2 = $clog2(MAX_MAP_SIDE);
  localparam int MAP_DEPTH     = MAX_MAP_SIDE * MAX_MAP_SIDE;
  localparam int MAP_AW        = $clog2(MAP_DEPTH);

  // cell size is a power of two: CELL_SIZE = 2**CELL_LOG2 pixels
  localparam int CELL_LOG2     = 6;
  localparam int CELL_SIZE     = 1 << CELL_LOG2;
  localparam int CQ8_LOG2      = CELL_LOG2 + 8;

  localparam int CFG_W   = 7;
  localparam int COL_W   = 6;
  localparam int PX_W    = 20;
  localparam int ANG_W   = 13;
  localparam int OUT_W   = 32;
  localparam int PHI_W   = 11;

  localparam int RX_W    = CQ8_LOG2 + 12;
  localparam int RY_W    = 48;
  localparam int TAN_W   = 42;
  localparam int LO_W    = TAN_W / 2;
  localparam int D_W     = CQ8_LOG2 + 2;
  localparam int PLO_W   = D_W + LO_W + 1;
  localparam int PHI_PW  = D_W + TAN_W - LO_W;
  localparam int PROD_W  = D_W + TAN_W + 1;
  localparam int YO_W    = TAN_W + 1 + CQ8_LOG2;
  localparam int CNT_W   = 7;

  localparam int CORDIC_STEPS = 20;
  localparam int XY_W    = 32;
  localparam int Z_W     = 24;
  localparam int MAG_W   = 32;
  localparam int DVD_W   = MAG_W + 16;
  localparam int ITER_W  = 6;

  localparam logic [ANG_W-1:0] ANGLE_FULL    = ANG_W'(5760);
  localparam logic [ANG_W-1:0] ANGLE_QUARTER = ANG_W'(1440);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_ROT,
    TS_PREP,
    TS_DIV,
    TS_FIN
  } tan_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAN_GO,
    ST_TAN_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_INIT,
    ST_WALK,
    ST_DONE
  } ctl_state_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = Z_W'(2949120);
      5'd1:  v = Z_W'(1740967);
      5'd2:  v = Z_W'(919879);
      5'd3:  v = Z_W'(466945);
      5'd4:  v = Z_W'(234379);
      5'd5:  v = Z_W'(117304);
      5'd6:  v = Z_W'(58666);
      5'd7:  v = Z_W'(29335);
      5'd8:  v = Z_W'(14668);
      5'd9:  v = Z_W'(7334);
      5'd10: v = Z_W'(3667);
      5'd11: v = Z_W'(1833);
      5'd12: v = Z_W'(917);
      5'd13: v = Z_W'(458);
      5'd14: v = Z_W'(229);
      5'd15: v = Z_W'(115);
      5'd16: v = Z_W'(57);
      5'd17: v = Z_W'(29);
      5'd18: v = Z_W'(14);
      5'd19: v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RY_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[RY_W-1:OUT_W-1] == '0 || v[RY_W-1:OUT_W-1] == '1) begin
      r = v[OUT_W-1:0];
    end else if (v[RY_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/ray_vertical_wall_hit_top.sv
// channel | direction | ports                                              | handshake
// in      | input     | in_kind in_cell_col in_cell_row in_cell_is_wall    | in_valid / in_ready
//         |           | in_player_x in_player_y in_ray_angle               |
// out     | output    | out_hit_x out_hit_y out_at_infinity                | out_valid / out_ready
// cfg     | input     | psel penable pwrite paddr pwdata prdata pready     | APB write, access phase
//
// A cast at exactly a quarter or three quarters of the full angle skips the tangent unit and walk.
// Any other cast walks n cells (at most max(width, height)) after the tangent unit runs its
// 20 CORDIC steps and a 48-step restoring divider, with one map read a step.
// Reset (rst_n low, synchronous) clears control only; the wall map holds no valid bits.
// A result waiting on out_ready holds the walker in its final state; map writes stay accepted
// only while no cast is in flight.
module ray_vertical_wall_hit_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [rvwh_pkg::COL_W-1:0]         in_cell_col,
  input  logic [rvwh_pkg::COL_W-1:0]         in_cell_row,
  input  logic                               in_cell_is_wall,
  input  logic [rvwh_pkg::PX_W-1:0]          in_player_x,
  input  logic [rvwh_pkg::PX_W-1:0]          in_player_y,
  input  logic [rvwh_pkg::ANG_W-1:0]         in_ray_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rvwh_pkg::OUT_W-1:0]  out_hit_x,
  output logic signed [rvwh_pkg::OUT_W-1:0]  out_hit_y,
  output logic                               out_at_infinity,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  rvwh_pkg::ctl_state_t st_r, st_nxt;

  logic [rvwh_pkg::CFG_W-1:0] map_width_r, map_height_r, map_w, map_h, steps;

  logic                              in_fire, cast_inf, cast_neg, cast_left;
  logic [rvwh_pkg::ANG_W-1:0]        t_mod;
  logic [rvwh_pkg::PHI_W-1:0]        cast_phi;
  logic [rvwh_pkg::PHI_W-1:0]        phi_r;
  logic                              neg_r, left_r;
  logic [rvwh_pkg::PX_W-1:0]         px_r, py_r;

  logic                              tan_start, tan_done;
  logic signed [rvwh_pkg::TAN_W-1:0] tan_q, tan_r;

  logic signed [rvwh_pkg::RX_W-1:0]  base, rx0, rx0_r, xo;
  logic signed [rvwh_pkg::D_W-1:0]   d_r;
  logic signed [rvwh_pkg::PLO_W-1:0] plo_r;
  logic signed [rvwh_pkg::PHI_PW-1:0] phi_prod_r;
  logic signed [rvwh_pkg::PROD_W-1:0] prod_sum;
  logic signed [rvwh_pkg::RY_W-1:0]  ry0, yo_r;
  logic signed [rvwh_pkg::TAN_W:0]   tan_dir;
  logic signed [rvwh_pkg::YO_W-1:0]  yo_wide;

  logic signed [rvwh_pkg::RX_W-1:0]  ix_r, cx_r;
  logic signed [rvwh_pkg::RY_W-1:0]  iy_r, cy_r;
  logic [rvwh_pkg::CNT_W-1:0]        icnt_r;
  logic                              chk_vld_r, chk_in_r, clast_r;
  logic                              in_x, in_y, hit, walk_end;

  logic signed [rvwh_pkg::RY_W-1:0]  fin_x_r, fin_y_r;
  logic                              fin_inf_r;
  logic signed [rvwh_pkg::OUT_W-1:0] out_hit_x_r, out_hit_y_r;
  logic                              out_valid_r, out_at_infinity_r;

  logic                              mem_we, mem_re, mem_rdata, wr_ok;
  logic [rvwh_pkg::MAP_AW-1:0]       mem_waddr, mem_raddr;
  logic                              cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == rvwh_pkg::REG_MAP_HEIGHT) ? {25'b0, map_height_r}
                                                         : {25'b0, map_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= rvwh_pkg::CFG_W'(64);
      map_height_r <= rvwh_pkg::CFG_W'(64);
    end else if (cfg_wr) begin
      if (paddr[2] == rvwh_pkg::REG_MAP_WIDTH) begin
        map_width_r <= pwdata[rvwh_pkg::CFG_W-1:0];
      end else begin
        map_height_r <= pwdata[rvwh_pkg::CFG_W-1:0];
      end
    end
  end

  assign map_w = (32'(map_width_r) > rvwh_pkg::MAX_MAP_SIDE) ?
                 rvwh_pkg::CFG_W'(rvwh_pkg::MAX_MAP_SIDE) : map_width_r;
  assign map_h = (32'(map_height_r) > rvwh_pkg::MAX_MAP_SIDE) ?
                 rvwh_pkg::CFG_W'(rvwh_pkg::MAX_MAP_SIDE) : map_height_r;
  assign steps = (map_w > map_h) ? map_w : map_h;

  // angle folding
  always_comb begin
    t_mod     = (in_ray_angle >= rvwh_pkg::ANGLE_FULL) ? in_ray_angle - rvwh_pkg::ANGLE_FULL
                                                      : in_ray_angle;
    cast_inf  = (t_mod == rvwh_pkg::ANGLE_QUARTER) ||
                (t_mod == rvwh_pkg::ANG_W'(3 * 1440));
    cast_left = (t_mod > rvwh_pkg::ANGLE_QUARTER) && (t_mod < rvwh_pkg::ANG_W'(3 * 1440));
    if (t_mod < rvwh_pkg::ANGLE_QUARTER) begin
      cast_phi = rvwh_pkg::PHI_W'(t_mod);
      cast_neg = 1'b0;
    end else if (t_mod < rvwh_pkg::ANG_W'(2 * 1440)) begin
      cast_phi = rvwh_pkg::PHI_W'(rvwh_pkg::ANG_W'(2 * 1440) - t_mod);
      cast_neg = 1'b1;
    end else if (t_mod < rvwh_pkg::ANG_W'(3 * 1440)) begin
      cast_phi = rvwh_pkg::PHI_W'(t_mod - rvwh_pkg::ANG_W'(2 * 1440));
      cast_neg = 1'b0;
    end else begin
      cast_phi = rvwh_pkg::PHI_W'(rvwh_pkg::ANGLE_FULL - t_mod);
      cast_neg = 1'b1;
    end
  end

  // first vertical line
  assign base = $signed({{(rvwh_pkg::RX_W - rvwh_pkg::PX_W){1'b0}},
                         px_r[rvwh_pkg::PX_W-1:rvwh_pkg::CQ8_LOG2],
                         {rvwh_pkg::CQ8_LOG2{1'b0}}});
  assign xo   = left_r ? -(rvwh_pkg::RX_W'(1) <<< rvwh_pkg::CQ8_LOG2)
                       : (rvwh_pkg::RX_W'(1) <<< rvwh_pkg::CQ8_LOG2);
  assign rx0  = left_r ? base - rvwh_pkg::RX_W'(1) : base + xo;

  assign tan_dir  = left_r ? (rvwh_pkg::TAN_W + 1)'(tan_r) : -((rvwh_pkg::TAN_W + 1)'(tan_r));
  assign yo_wide  = rvwh_pkg::YO_W'(tan_dir) <<< rvwh_pkg::CQ8_LOG2;
  assign prod_sum = (rvwh_pkg::PROD_W'(phi_prod_r) <<< rvwh_pkg::LO_W) +
                    rvwh_pkg::PROD_W'(plo_r);
  assign ry0      = rvwh_pkg::RY_W'(prod_sum >>> 16) +
                    $signed({{(rvwh_pkg::RY_W - rvwh_pkg::PX_W){1'b0}}, py_r});

  // map walk
  assign in_x = !ix_r[rvwh_pkg::RX_W-1] &&
                (ix_r[rvwh_pkg::RX_W-1:rvwh_pkg::CQ8_LOG2] <
                 (rvwh_pkg::RX_W - rvwh_pkg::CQ8_LOG2)'(map_w));
  assign in_y = !iy_r[rvwh_pkg::RY_W-1] &&
                (iy_r[rvwh_pkg::RY_W-1:rvwh_pkg::CQ8_LOG2] <
                 (rvwh_pkg::RY_W - rvwh_pkg::CQ8_LOG2)'(map_h));
  assign hit      = chk_vld_r && chk_in_r && mem_rdata;
  assign walk_end = chk_vld_r && (hit || clast_r);

  assign mem_raddr = rvwh_pkg::MAP_AW'(
      32'(iy_r[rvwh_pkg::CQ8_LOG2 +: rvwh_pkg::MAP_SIDE_LOG2]) * rvwh_pkg::MAX_MAP_SIDE +
      32'(ix_r[rvwh_pkg::CQ8_LOG2 +: rvwh_pkg::MAP_SIDE_LOG2]));
  assign mem_waddr = rvwh_pkg::MAP_AW'(32'(in_cell_row) * rvwh_pkg::MAX_MAP_SIDE +
                                       32'(in_cell_col));
  assign wr_ok     = (32'(in_cell_col) < rvwh_pkg::MAX_MAP_SIDE) &&
                     (32'(in_cell_row) < rvwh_pkg::MAX_MAP_SIDE);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rvwh_pkg::ST_IDLE: begin
        if (in_fire && in_kind == rvwh_pkg::KIND_CAST) begin
          st_nxt = cast_inf ? rvwh_pkg::ST_DONE : rvwh_pkg::ST_TAN_GO;
        end
      end
      rvwh_pkg::ST_TAN_GO:   st_nxt = rvwh_pkg::ST_TAN_WAIT;
      rvwh_pkg::ST_TAN_WAIT: if (tan_done) st_nxt = rvwh_pkg::ST_MUL_LO;
      rvwh_pkg::ST_MUL_LO:   st_nxt = rvwh_pkg::ST_MUL_HI;
      rvwh_pkg::ST_MUL_HI:   st_nxt = rvwh_pkg::ST_INIT;
      rvwh_pkg::ST_INIT:     st_nxt = (steps == '0) ? rvwh_pkg::ST_DONE : rvwh_pkg::ST_WALK;
      rvwh_pkg::ST_WALK:     if (walk_end) st_nxt = rvwh_pkg::ST_DONE;
      rvwh_pkg::ST_DONE:     if (!out_valid_r || out_ready) st_nxt = rvwh_pkg::ST_IDLE;
      default:               st_nxt = rvwh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == rvwh_pkg::ST_IDLE);
    in_fire   = in_valid && in_ready;
    tan_start = (st_r == rvwh_pkg::ST_TAN_GO);
    mem_re    = (st_r == rvwh_pkg::ST_WALK) && !walk_end;
    mem_we    = in_fire && (in_kind == rvwh_pkg::KIND_WRITE) && wr_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rvwh_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      case (st_r)
        rvwh_pkg::ST_INIT: chk_vld_r <= 1'b0;
        rvwh_pkg::ST_WALK: chk_vld_r <= !walk_end;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      rvwh_pkg::ST_IDLE: begin
        if (in_fire) begin
          px_r      <= in_player_x;
          py_r      <= in_player_y;
          phi_r     <= cast_phi;
          neg_r     <= cast_neg;
          left_r    <= cast_left;
          fin_x_r   <= rvwh_pkg::RY_W'(32'sh7FFF_FFFF);
          fin_y_r   <= rvwh_pkg::RY_W'(32'sh7FFF_FFFF);
          fin_inf_r <= 1'b1;
        end
      end
      rvwh_pkg::ST_TAN_GO: begin
        rx0_r <= rx0;
        d_r   <= rvwh_pkg::D_W'($signed({{(rvwh_pkg::RX_W - rvwh_pkg::PX_W){1'b0}}, px_r}) - rx0);
      end
      rvwh_pkg::ST_TAN_WAIT: begin
        if (tan_done) begin
          tan_r <= neg_r ? -tan_q : tan_q;
        end
      end
      rvwh_pkg::ST_MUL_LO: begin
        plo_r <= d_r * $signed({1'b0, tan_r[rvwh_pkg::LO_W-1:0]});
        yo_r  <= rvwh_pkg::RY_W'(yo_wide >>> 16);
      end
      rvwh_pkg::ST_MUL_HI: begin
        phi_prod_r <= d_r * $signed(tan_r[rvwh_pkg::TAN_W-1:rvwh_pkg::LO_W]);
      end
      rvwh_pkg::ST_INIT: begin
        ix_r      <= rx0_r;
        iy_r      <= ry0;
        icnt_r    <= '0;
        fin_x_r   <= rvwh_pkg::RY_W'(rx0_r);
        fin_y_r   <= ry0;
        fin_inf_r <= 1'b0;
      end
      rvwh_pkg::ST_WALK: begin
        if (walk_end) begin
          fin_x_r <= hit ? rvwh_pkg::RY_W'(cx_r) : rvwh_pkg::RY_W'(ix_r);
          fin_y_r <= hit ? cy_r : iy_r;
        end else begin
          chk_in_r <= in_x && in_y;
          cx_r     <= ix_r;
          cy_r     <= iy_r;
          clast_r  <= (icnt_r == steps - 1'b1);
          ix_r     <= ix_r + xo;
          iy_r     <= iy_r + yo_r;
          icnt_r   <= icnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == rvwh_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == rvwh_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_hit_x_r       <= rvwh_pkg::sat_out(fin_x_r);
      out_hit_y_r       <= rvwh_pkg::sat_out(fin_y_r);
      out_at_infinity_r <= fin_inf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit_x       = out_hit_x_r;
  assign out_hit_y       = out_hit_y_r;
  assign out_at_infinity = out_at_infinity_r;

  rvwh_tan_unit u_tan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tan_start),
    .phi   (phi_r),
    .done  (tan_done),
    .tan   (tan_q)
  );

  rvwh_map_ram u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_cell_is_wall),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rvwh_pkg::ST_WALK && chk_vld_r) |-> (icnt_r != '0 && icnt_r <= steps))
    else $error("walk check without an issued step");

  a_inf_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_at_infinity_r) |->
      (out_hit_x_r == 32'sh7FFF_FFFF && out_hit_y_r == 32'sh7FFF_FFFF))
    else $error("infinity result without saturated point");

  a_tan_done: assert property (@(posedge clk) disable iff (!rst_n)
    tan_done |-> (st_r == rvwh_pkg::ST_TAN_WAIT))
    else $error("tangent finished outside of a cast");

  a_map_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("map written during a walk");

endmodule

### rtl/rvwh_map_ram.sv
module rvwh_map_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rvwh_pkg::MAP_AW-1:0] waddr,
  input  logic                       wdata,
  input  logic                       re,
  input  logic [rvwh_pkg::MAP_AW-1:0] raddr,
  output logic                       rdata
);

  logic mem [rvwh_pkg::MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rvwh_tan_unit.sv
module rvwh_tan_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rvwh_pkg::PHI_W-1:0]        phi,
  output logic                              done,
  output logic signed [rvwh_pkg::TAN_W-1:0] tan
);

  rvwh_pkg::tan_state_t st_r, st_nxt;

  logic signed [rvwh_pkg::XY_W-1:0]  x_r, y_r, xs, ys;
  logic signed [rvwh_pkg::Z_W-1:0]   z_r, at;
  logic [rvwh_pkg::ITER_W-1:0]       i_r;
  logic [rvwh_pkg::DVD_W-1:0]        dvd_r, q_r;
  logic [rvwh_pkg::MAG_W:0]          rem_r, rem_sh, x_ext;
  logic                              yneg_r, ge;
  logic [rvwh_pkg::MAG_W-1:0]        y_mag;
  logic [rvwh_pkg::DVD_W-1:0]        q_fix;

  assign xs     = x_r >>> i_r[4:0];
  assign ys     = y_r >>> i_r[4:0];
  assign at     = rvwh_pkg::atan_q16(i_r[4:0]);
  assign rem_sh = {rem_r[rvwh_pkg::MAG_W-1:0], dvd_r[rvwh_pkg::DVD_W-1]};
  assign x_ext  = {1'b0, x_r};
  assign ge     = rem_sh >= x_ext;
  assign y_mag  = y_r[rvwh_pkg::XY_W-1] ? rvwh_pkg::MAG_W'(-y_r) : rvwh_pkg::MAG_W'(y_r);
  assign q_fix  = q_r + rvwh_pkg::DVD_W'(rem_r != '0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rvwh_pkg::TS_IDLE: if (start) st_nxt = rvwh_pkg::TS_ROT;
      rvwh_pkg::TS_ROT: begin
        if (i_r == rvwh_pkg::ITER_W'(rvwh_pkg::CORDIC_STEPS - 1)) st_nxt = rvwh_pkg::TS_PREP;
      end
      rvwh_pkg::TS_PREP: st_nxt = rvwh_pkg::TS_DIV;
      rvwh_pkg::TS_DIV: begin
        if (i_r == rvwh_pkg::ITER_W'(rvwh_pkg::DVD_W - 1)) st_nxt = rvwh_pkg::TS_FIN;
      end
      rvwh_pkg::TS_FIN: st_nxt = rvwh_pkg::TS_IDLE;
      default: st_nxt = rvwh_pkg::TS_IDLE;
    endcase
  end

  always_comb begin
    done = (st_r == rvwh_pkg::TS_FIN);
    if (x_r <= 0) begin
      tan = rvwh_pkg::TAN_W'(64'sd1 << 40);
    end else if (yneg_r) begin
      tan = -$signed(rvwh_pkg::TAN_W'(q_fix));
    end else begin
      tan = $signed(rvwh_pkg::TAN_W'(q_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rvwh_pkg::TS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      rvwh_pkg::TS_IDLE: begin
        x_r <= rvwh_pkg::XY_W'(32'sd1 << 28);
        y_r <= '0;
        z_r <= $signed({1'b0, phi, 12'b0});
        i_r <= '0;
      end
      rvwh_pkg::TS_ROT: begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
      end
      rvwh_pkg::TS_PREP: begin
        dvd_r  <= {y_mag, 16'b0};
        rem_r  <= '0;
        q_r    <= '0;
        yneg_r <= y_r[rvwh_pkg::XY_W-1];
        i_r    <= '0;
      end
      rvwh_pkg::TS_DIV: begin
        rem_r <= ge ? rem_sh - x_ext : rem_sh;
        q_r   <= {q_r[rvwh_pkg::DVD_W-2:0], ge};
        dvd_r <= {dvd_r[rvwh_pkg::DVD_W-2:0], 1'b0};
        i_r   <= i_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
